@@ hdl/nhm_pkg.sv @@
`timescale 1ns / 1ps

package nhm_pkg;

    // Table geometry and reset values
    localparam int          NODE_COUNT        = 16;
    localparam int          NODE_W            = $clog2(NODE_COUNT);
    localparam logic [15:0] DEFAULT_LINK_COST = 16'd1;
    localparam logic [15:0] TTL_RESET         = 16'd1000;
    localparam logic [15:0] AGE_MAX           = 16'hFFFF;

    // Configuration register indexes
    localparam logic CFG_OWN_NODE  = 1'b0;
    localparam logic CFG_TTL_TICKS = 1'b1;

    // Command codes
    typedef enum logic [3:0] {
        CMD_TICK     = 4'd0,
        CMD_BEAT     = 4'd1,
        CMD_SET_COST = 4'd2,
        CMD_GET_COST = 4'd3,
        CMD_DISCOVER = 4'd4,
        CMD_QUERY    = 4'd5,
        CMD_DOWN     = 4'd6,
        CMD_ACTIVE   = 4'd7,
        CMD_RECIP    = 4'd8
    } t_cmd;

    // One neighbour table entry
    typedef struct packed {
        logic [15:0] age;
        logic [15:0] cost;
        logic        heard;
        logic        act_now;
        logic        act_before;
        logic        disc;
    } t_entry;

    // Result of evaluating one entry
    typedef struct packed {
        t_entry nxt;
        logic   live;
        logic   hit;
        logic   wr;
    } t_eval;

    // One output word
    typedef struct packed {
        logic        status;
        logic [3:0]  node_out;
        logic [15:0] cost_out;
        logic        is_active;
        logic        is_heard;
        logic        is_discovered;
        logic        id_valid;
        logic        last;
    } t_result;

endpackage

@@ hdl/neighbor_heartbeat_monitor.sv @@
`timescale 1ns / 1ps

// Channel   Dir  tdata (low bit up)                       tuser           tlast
// s_*       in   node[3:0] cost_in[19:4] path_mask[35:20] cmd[3:0]        -
// m_*       out  node_out cost_out is_active is_heard     status id_valid last
//                is_discovered (bits 23:0)
// cfg       in   i_cfg_we, i_cfg_idx (0 own_node, 1 ttl_ticks), i_cfg_data
//
// Tick: accepted, then a scan of the whole table; no word out.
// Commands 1 to 5: accepted, then executed on the addressed entry.
// Lists: accepted, then a scan of the whole table, then a closing step; the scan
// goes one table entry a cycle, when not stalled, through the shared entry unit.
// A full output register stalls the scan when a further hit is found, and
// holds the execute or closing step until it frees up.
// Reset (synchronous) clears the table to its reset values at once.
module neighbor_heartbeat_monitor
    import nhm_pkg::*;
(
    input  logic        i_clk,
    input  logic        i_rst_n,
    // input stream
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [39:0] s_tdata,   // node, cost_in, path_mask, zero fill
    input  logic [3:0]  s_tuser,   // cmd
    // output stream
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [23:0] m_tdata,   // node_out, cost_out, is_active, is_heard,
                                   // is_discovered, zero fill
    output logic [1:0]  m_tuser,   // status, id_valid
    output logic        m_tlast,
    // configuration
    input  logic        i_cfg_we,
    input  logic        i_cfg_idx,
    input  logic [15:0] i_cfg_data
);

    typedef enum logic [1:0] {
        S_IDLE,
        S_ONE,
        S_SCAN,
        S_DONE
    } t_state;

    t_state              r_state;
    t_cmd                r_cmd;
    logic [3:0]          r_node;
    logic [15:0]         r_cost;
    logic [15:0]         r_mask;
    logic [NODE_W-1:0]   r_idx;
    logic [3:0]          r_own;
    logic [15:0]         r_ttl;

    logic [15:0]         r_age      [NODE_COUNT];
    logic [15:0]         r_link     [NODE_COUNT];
    logic [NODE_COUNT-1:0] r_heard;
    logic [NODE_COUNT-1:0] r_act_now;
    logic [NODE_COUNT-1:0] r_act_before;
    logic [NODE_COUNT-1:0] r_disc;

    logic                r_pend_valid;
    t_result             r_pend;
    logic                r_o_valid;
    t_result             r_o;

    logic [NODE_W-1:0]   w_addr;
    t_entry              w_cur;
    t_eval               w_ev;
    logic                w_own;
    logic                w_bad;
    logic                w_out_free;
    logic                w_emit;
    t_result             w_emit_data;
    t_result             w_entry_res;
    t_result             w_blank;
    logic                w_wr;
    logic                w_stall;
    logic                w_accept;

    assign w_accept   = s_tvalid && s_tready;
    assign s_tready   = (r_state == S_IDLE);
    assign w_out_free = !r_o_valid || m_tready;

    // Select the entry under work
    assign w_addr = (r_state == S_ONE) ? r_node[NODE_W-1:0] : r_idx;
    assign w_own  = (4'(w_addr) == r_own);
    assign w_bad  = (32'(r_node) >= NODE_COUNT) || (r_node == r_own);

    always_comb begin
        w_cur.age        = r_age[w_addr];
        w_cur.cost       = r_link[w_addr];
        w_cur.heard      = r_heard[w_addr];
        w_cur.act_now    = r_act_now[w_addr];
        w_cur.act_before = r_act_before[w_addr];
        w_cur.disc       = r_disc[w_addr];
    end

    nhm_entry_eval u_eval (
        .i_entry    (w_cur),
        .i_cmd      (r_cmd),
        .i_cost     (r_cost),
        .i_mask_bit (r_mask[w_addr]),
        .i_own      (w_own),
        .i_ttl      (r_ttl),
        .o_res      (w_ev)
    );

    // Word for the current entry after its update
    always_comb begin
        w_entry_res               = '0;
        w_entry_res.node_out      = 4'(w_addr);
        w_entry_res.cost_out      = w_ev.nxt.cost;
        w_entry_res.is_active     = w_ev.live;
        w_entry_res.is_heard      = w_ev.nxt.heard;
        w_entry_res.is_discovered = w_ev.nxt.disc;
        w_entry_res.id_valid      = 1'b1;
    end

    // Sequencer decisions: emit, write back, stall
    always_comb begin
        w_emit      = 1'b0;
        w_emit_data = w_entry_res;
        w_wr        = 1'b0;
        w_stall     = 1'b0;
        w_blank     = '0;
        w_blank.last = 1'b1;
        case (r_state)
            S_ONE: begin
                w_emit = w_out_free;
                w_wr   = w_out_free && !w_bad;
                if (w_bad) begin
                    w_blank.status   = 1'b1;
                    w_blank.node_out = r_node;
                    w_emit_data      = w_blank;
                end else begin
                    w_emit_data.last = 1'b1;
                end
            end
            S_SCAN: begin
                w_stall     = w_ev.hit && r_pend_valid && !w_out_free;
                w_emit      = w_ev.hit && r_pend_valid && w_out_free;
                w_emit_data = r_pend;
                w_wr        = !w_stall && w_ev.wr;
            end
            S_DONE: begin
                w_emit = w_out_free;
                if (r_pend_valid) begin
                    w_emit_data      = r_pend;
                    w_emit_data.last = 1'b1;
                end else begin
                    w_emit_data = w_blank;
                end
            end
            default: ;
        endcase
    end

    // State, table, pending word and output register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state      <= S_IDLE;
            r_own        <= 4'd0;
            r_ttl        <= TTL_RESET;
            r_pend_valid <= 1'b0;
            r_o_valid    <= 1'b0;
            r_idx        <= '0;
            r_heard      <= '0;
            r_act_now    <= '0;
            r_act_before <= '0;
            r_disc       <= '0;
            for (int k = 0; k < NODE_COUNT; k++) begin
                r_age[k]  <= 16'd0;
                r_link[k] <= DEFAULT_LINK_COST;
            end
        end else begin
            // Configuration writes
            if (i_cfg_we) begin
                case (i_cfg_idx)
                    CFG_OWN_NODE:  r_own <= i_cfg_data[3:0];
                    CFG_TTL_TICKS: r_ttl <= i_cfg_data;
                    default: ;
                endcase
            end

            // Write back the evaluated entry
            if (w_wr) begin
                r_age[w_addr]        <= w_ev.nxt.age;
                r_link[w_addr]       <= w_ev.nxt.cost;
                r_heard[w_addr]      <= w_ev.nxt.heard;
                r_act_now[w_addr]    <= w_ev.nxt.act_now;
                r_act_before[w_addr] <= w_ev.nxt.act_before;
                r_disc[w_addr]       <= w_ev.nxt.disc;
            end

            // Output register: load on emit, drop when taken
            if (w_emit) begin
                r_o_valid <= 1'b1;
                r_o       <= w_emit_data;
            end else if (m_tready) begin
                r_o_valid <= 1'b0;
            end

            case (r_state)
                S_IDLE: begin
                    if (w_accept) begin
                        r_cmd  <= t_cmd'(s_tuser);
                        r_node <= s_tdata[3:0];
                        r_cost <= s_tdata[19:4];
                        r_mask <= s_tdata[35:20];
                        r_idx  <= '0;
                        if (s_tuser inside {CMD_TICK, CMD_DOWN, CMD_ACTIVE, CMD_RECIP}) begin
                            r_state <= S_SCAN;
                        end else if (s_tuser inside {[CMD_BEAT:CMD_QUERY]}) begin
                            r_state <= S_ONE;
                        end
                    end
                end
                S_ONE: begin
                    if (w_out_free) begin
                        r_state <= S_IDLE;
                    end
                end
                S_SCAN: begin
                    if (!w_stall) begin
                        // Hold the newest hit until the next one or the end
                        if (w_ev.hit) begin
                            r_pend_valid <= 1'b1;
                            r_pend       <= w_entry_res;
                        end
                        if (r_idx == NODE_W'(NODE_COUNT - 1)) begin
                            r_state <= (r_cmd == CMD_TICK) ? S_IDLE : S_DONE;
                        end else begin
                            r_idx <= r_idx + NODE_W'(1);
                        end
                    end
                end
                S_DONE: begin
                    if (w_out_free) begin
                        r_pend_valid <= 1'b0;
                        r_state      <= S_IDLE;
                    end
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end

    // Pack the output word
    assign m_tvalid = r_o_valid;
    assign m_tdata  = {1'b0, r_o.is_discovered, r_o.is_heard, r_o.is_active,
                       r_o.cost_out, r_o.node_out};
    assign m_tuser  = {r_o.id_valid, r_o.status};
    assign m_tlast  = r_o.last;

    // A tick never produces a word
    a_tick_silent: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_SCAN && r_cmd == CMD_TICK) |-> !w_emit)
        else $error("tick scan emitted a word");

    // The own node is never listed
    a_own_unlisted: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_emit && w_emit_data.id_valid && r_state != S_ONE) |->
        (w_emit_data.node_out != r_own))
        else $error("own node listed");

    // A pending hit exists only while a list is in progress
    a_pend_scope: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_pend_valid |-> (r_state == S_SCAN || r_state == S_DONE))
        else $error("pending hit outside a list");

    // Closing a list clears the pending hit and returns to idle
    a_done_close: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_DONE && w_out_free) |=> (!r_pend_valid && r_state == S_IDLE))
        else $error("list did not close");

endmodule

@@ hdl/nhm_entry_eval.sv @@
`timescale 1ns / 1ps

// Shared entry unit: applies one command to one table entry, does the
// liveness compare against the ttl and decides whether the entry is listed.
module nhm_entry_eval
    import nhm_pkg::*;
(
    input  t_entry      i_entry,
    input  t_cmd        i_cmd,
    input  logic [15:0] i_cost,
    input  logic        i_mask_bit,
    input  logic        i_own,
    input  logic [15:0] i_ttl,
    output t_eval       o_res
);

    t_entry v_nxt;
    logic   v_live;
    logic   v_hit;
    logic   v_wr;

    always_comb begin
        v_nxt = i_entry;
        v_hit = 1'b0;
        v_wr  = 1'b1;

        // Apply field updates of the addressed or scanned entry
        case (i_cmd)
            CMD_TICK: begin
                if (i_entry.age != AGE_MAX) begin
                    v_nxt.age = i_entry.age + 16'd1;
                end
            end
            CMD_BEAT: begin
                v_nxt.age     = 16'd0;
                v_nxt.heard   = 1'b1;
                v_nxt.act_now = 1'b1;
            end
            CMD_SET_COST: v_nxt.cost = i_cost;
            CMD_DISCOVER: v_nxt.disc = 1'b1;
            default: ;
        endcase

        // Liveness of the updated entry
        v_live = v_nxt.heard && (v_nxt.age < i_ttl);

        // Recompute and list decision
        case (i_cmd)
            CMD_DOWN: begin
                if (i_own || !i_entry.heard) begin
                    v_wr = 1'b0;
                end else if (i_entry.act_before) begin
                    // Recompute a node that was active; list it once stale
                    v_hit            = !v_live;
                    v_nxt.act_now    = v_live;
                    v_nxt.act_before = v_live;
                    if (!v_live) begin
                        v_nxt.disc = 1'b0;
                    end
                end else begin
                    // Carry the current flag over, no recompute
                    v_nxt.act_before = i_entry.act_now;
                end
            end
            CMD_ACTIVE: begin
                if (i_own) begin
                    v_wr = 1'b0;
                end else begin
                    v_hit         = v_live;
                    v_nxt.act_now = v_live;
                    if (!v_live) begin
                        v_nxt.disc = 1'b0;
                    end
                end
            end
            CMD_RECIP: begin
                v_wr  = 1'b0;
                v_hit = !i_own && i_entry.heard && !i_mask_bit;
            end
            default: ;
        endcase

        o_res.nxt  = v_nxt;
        o_res.live = v_live;
        o_res.hit  = v_hit;
        o_res.wr   = v_wr;
    end

endmodule

@@ test/neighbor_heartbeat_monitor_tb.sv @@
`timescale 1ns / 1ps

module neighbor_heartbeat_monitor_tb;
    import nhm_pkg::*;

    // Codes the block must ignore
    localparam logic [3:0] CMD_SPARE_LO = 4'd9;
    localparam logic [3:0] CMD_SPARE_HI = 4'd15;

    // Cycles to let a tick scan finish before the block counts as idle
    localparam int SETTLE_CYCLES = 40;

    logic        i_clk = 1'b0;
    logic        i_rst_n;
    logic        s_tvalid;
    logic        s_tready;
    logic [39:0] s_tdata;   // node, cost_in, path_mask, zero fill
    logic [3:0]  s_tuser;   // cmd
    logic        m_tvalid;
    logic        m_tready;
    logic [23:0] m_tdata;   // node_out, cost_out, is_active, is_heard,
                            // is_discovered, zero fill
    logic [1:0]  m_tuser;   // status, id_valid
    logic        m_tlast;
    logic        i_cfg_we;
    logic        i_cfg_idx;
    logic [15:0] i_cfg_data;

    neighbor_heartbeat_monitor DUT (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .s_tvalid   (s_tvalid),
        .s_tready   (s_tready),
        .s_tdata    (s_tdata),
        .s_tuser    (s_tuser),
        .m_tvalid   (m_tvalid),
        .m_tready   (m_tready),
        .m_tdata    (m_tdata),
        .m_tuser    (m_tuser),
        .m_tlast    (m_tlast),
        .i_cfg_we   (i_cfg_we),
        .i_cfg_idx  (i_cfg_idx),
        .i_cfg_data (i_cfg_data)
    );

    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    // Shadow of the neighbour table and of the two registers
    logic [15:0] nb_age   [NODE_COUNT];
    logic        nb_heard [NODE_COUNT];
    logic        nb_now   [NODE_COUNT];
    logic        nb_prev  [NODE_COUNT];
    logic        nb_disc  [NODE_COUNT];
    logic [15:0] nb_cost  [NODE_COUNT];
    logic [3:0]  own_id;
    logic [15:0] ttl_ticks;

    t_result expected_words[$];
    int      word_errors = 0;
    int      burst_left  = 0;

    function automatic void table_reset();
        for (int i = 0; i < NODE_COUNT; i++) begin
            nb_age[i]   = '0;
            nb_heard[i] = 1'b0;
            nb_now[i]   = 1'b0;
            nb_prev[i]  = 1'b0;
            nb_disc[i]  = 1'b0;
            nb_cost[i]  = DEFAULT_LINK_COST;
        end
        own_id    = '0;
        ttl_ticks = TTL_RESET;
    endfunction

    // Append one word to the tail of the expected queue
    function automatic void expect_word(t_result w);
        expected_words.insert(expected_words.size(), w);
    endfunction

    function automatic logic is_live(int i);
        return nb_heard[i] && (nb_age[i] < ttl_ticks);
    endfunction

    // Store liveness, drop discovered on a stale node
    function automatic logic refresh_entry(int i);
        logic live;
        live      = is_live(i);
        nb_now[i] = live;
        if (!live)
            nb_disc[i] = 1'b0;
        return live;
    endfunction

    function automatic t_result entry_word(int i, logic last);
        t_result w;
        w.status        = 1'b0;
        w.node_out      = i[3:0];
        w.cost_out      = nb_cost[i];
        w.is_active     = is_live(i);
        w.is_heard      = nb_heard[i];
        w.is_discovered = nb_disc[i];
        w.id_valid      = 1'b1;
        w.last          = last;
        return w;
    endfunction

    function automatic t_result blank_word(logic status, logic [3:0] node);
        t_result w;
        w          = '0;
        w.status   = status;
        w.node_out = node;
        w.last     = 1'b1;
        return w;
    endfunction

    // Update the shadow table for one accepted word and queue its results
    function automatic void table_apply(logic [3:0] cmd, logic [3:0] node,
                                        logic [15:0] cost, logic [15:0] mask);
        t_result hits[$];
        logic    hit;
        int      n;
        n = int'(node);
        if (cmd == CMD_TICK) begin
            for (int i = 0; i < NODE_COUNT; i++)
                if (nb_age[i] < AGE_MAX)
                    nb_age[i] = nb_age[i] + 16'd1;
        end else if (cmd >= CMD_BEAT && cmd <= CMD_QUERY) begin
            if (n >= NODE_COUNT || node == own_id) begin
                expect_word(blank_word(1'b1, node));
            end else begin
                case (cmd)
                    CMD_BEAT: begin
                        nb_age[n]   = '0;
                        nb_heard[n] = 1'b1;
                        nb_now[n]   = 1'b1;
                    end
                    CMD_SET_COST: nb_cost[n] = cost;
                    CMD_DISCOVER: nb_disc[n] = 1'b1;
                    default: ;
                endcase
                expect_word(entry_word(n, 1'b1));
            end
        end else if (cmd >= CMD_DOWN && cmd <= CMD_RECIP) begin
            for (int i = 0; i < NODE_COUNT; i++) begin
                hit = 1'b0;
                if (i == own_id)
                    continue;
                if (cmd == CMD_DOWN) begin
                    if (!nb_heard[i])
                        continue;
                    // only a node that was active is recomputed here
                    if (nb_prev[i])
                        hit = !refresh_entry(i);
                    nb_prev[i] = nb_now[i];
                end else if (cmd == CMD_ACTIVE) begin
                    hit = refresh_entry(i);
                end else begin
                    hit = nb_heard[i] && !mask[i];
                end
                if (hit)
                    hits.insert(hits.size(), entry_word(i, 1'b0));
            end
            if (hits.size() == 0) begin
                expect_word(blank_word(1'b0, 4'd0));
            end else begin
                hits[hits.size() - 1].last = 1'b1;
                foreach (hits[k])
                    expect_word(hits[k]);
            end
        end
    endfunction

    function automatic string word_text(t_result w);
        return $sformatf("st=%0d id=%0d cost=%0d act=%0d heard=%0d disc=%0d val=%0d last=%0d",
                         w.status, w.node_out, w.cost_out, w.is_active, w.is_heard,
                         w.is_discovered, w.id_valid, w.last);
    endfunction

    // Send one word in bursts with random gaps, then shadow it on acceptance
    task automatic send_word(logic [3:0] cmd, logic [3:0] node,
                             logic [15:0] cost, logic [15:0] mask);
        int gap;
        if (burst_left == 0) begin
            gap = ($urandom_range(0, 3) == 0) ? $urandom_range(4, 24) : $urandom_range(1, 3);
            s_tvalid <= 1'b0;
            repeat (gap) @(posedge i_clk);
            burst_left = $urandom_range(1, 12);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= {4'b0, mask, cost, node};
        s_tuser  <= cmd;
        do @(posedge i_clk); while (!s_tready);
        table_apply(cmd, node, cost, mask);
        burst_left--;
    endtask

    // Hold the input until every expected word is out and any scan has ended
    task automatic drain();
        s_tvalid <= 1'b0;
        while (expected_words.size() != 0)
            @(posedge i_clk);
        repeat (SETTLE_CYCLES) @(posedge i_clk);
    endtask

    task automatic write_config(logic [3:0] own, logic [15:0] ttl);
        drain();
        i_cfg_we   <= 1'b1;
        i_cfg_idx  <= CFG_OWN_NODE;
        i_cfg_data <= {12'b0, own};
        @(posedge i_clk);
        own_id      = own;
        i_cfg_idx  <= CFG_TTL_TICKS;
        i_cfg_data <= ttl;
        @(posedge i_clk);
        ttl_ticks   = ttl;
        i_cfg_we   <= 1'b0;
    endtask

    // Fresh table: own id refused, every list empty
    task automatic test_empty_table();
        send_word(CMD_QUERY, 4'd0, 16'h0000, 16'h0000);
        send_word(CMD_QUERY, 4'd15, 16'hFFFF, 16'hFFFF);
        send_word(CMD_BEAT, 4'd0, 16'h0000, 16'h0000);
        send_word(CMD_DOWN, 4'd0, 16'h0000, 16'h0000);
        send_word(CMD_ACTIVE, 4'd0, 16'h0000, 16'h0000);
        send_word(CMD_RECIP, 4'd0, 16'h0000, 16'h0000);
    endtask

    // Per-entry commands at the id and cost extremes
    task automatic test_entry_commands();
        send_word(CMD_BEAT, 4'd15, 16'h0000, 16'h0000);
        send_word(CMD_BEAT, 4'd1, 16'h0000, 16'h0000);
        send_word(CMD_SET_COST, 4'd1, 16'hFFFF, 16'h0000);
        send_word(CMD_SET_COST, 4'd15, 16'h0000, 16'hFFFF);
        send_word(CMD_GET_COST, 4'd1, 16'h0000, 16'h0000);
        send_word(CMD_DISCOVER, 4'd15, 16'h0000, 16'h0000);
        send_word(CMD_QUERY, 4'd15, 16'h0000, 16'h0000);
    endtask

    // Lists, masks, a tick and the spare codes
    task automatic test_lists();
        send_word(CMD_ACTIVE, 4'd0, 16'h0000, 16'h0000);
        send_word(CMD_RECIP, 4'd0, 16'h0000, 16'hFFFF);
        send_word(CMD_RECIP, 4'd0, 16'h0000, 16'h0002);
        send_word(CMD_TICK, 4'd0, 16'h0000, 16'h0000);
        send_word(CMD_SPARE_LO, 4'd15, 16'hFFFF, 16'hFFFF);
        send_word(CMD_SPARE_HI, 4'd0, 16'h0000, 16'h0000);
        send_word(CMD_DOWN, 4'd0, 16'h0000, 16'h0000);
    endtask

    // Shortest and zero ttl: nodes drop out after one tick or never count
    task automatic test_ttl_limits();
        write_config(4'd15, 16'd1);
        send_word(CMD_BEAT, 4'd1, 16'h0000, 16'h0000);
        send_word(CMD_TICK, 4'd0, 16'h0000, 16'h0000);
        send_word(CMD_QUERY, 4'd1, 16'h0000, 16'h0000);
        send_word(CMD_DOWN, 4'd0, 16'h0000, 16'h0000);
        write_config(4'd7, 16'd0);
        send_word(CMD_BEAT, 4'd3, 16'h0000, 16'h0000);
        send_word(CMD_ACTIVE, 4'd0, 16'h0000, 16'h0000);
    endtask

    task automatic random_phase(logic [3:0] own, logic [15:0] ttl, int count);
        int         pick;
        int         done;
        logic [3:0] cmd;
        write_config(own, ttl);
        done = 0;
        while (done < count) begin
            pick = $urandom_range(0, 99);
            if (pick < 30)
                cmd = CMD_BEAT;
            else if (pick < 50)
                cmd = CMD_TICK;
            else if (pick < 65)
                cmd = 4'(CMD_DOWN + $urandom_range(0, 2));
            else if (pick < 93)
                cmd = 4'(CMD_SET_COST + $urandom_range(0, 3));
            else
                cmd = 4'($urandom_range(CMD_SPARE_LO, CMD_SPARE_HI));
            send_word(cmd, 4'($urandom_range(0, 15)), 16'($urandom()), 16'($urandom()));
            if (cmd <= CMD_RECIP)
                done++;
        end
    endtask

    task automatic test_random_traffic();
        random_phase(4'($urandom_range(0, 15)), 16'($urandom_range(2, 6)), 50);
        random_phase(4'd0, 16'hFFFF, 35);
        random_phase(4'd15, 16'd1, 35);
        random_phase(4'($urandom_range(0, 15)), 16'($urandom_range(8, 30)), 40);
        random_phase(4'($urandom_range(0, 15)), 16'd0, 20);
    endtask

    // Receiver: stall on a random pattern that is redrawn periodically
    initial begin
        logic [15:0] stall_pattern;
        int unsigned step;
        m_tready <= 1'b0;
        stall_pattern = 16'hFFFF;
        step = 0;
        forever begin
            @(posedge i_clk);
            if (step % 64 == 0)
                stall_pattern = ($urandom_range(0, 2) == 0) ? 16'hFFFF
                                                            : (16'($urandom()) | 16'h0001);
            m_tready <= stall_pattern[step % 16];
            step++;
        end
    end

    // Compare every accepted output word with the oldest expected one
    always @(posedge i_clk) begin : check_words
        t_result got;
        t_result want;
        if (i_rst_n && m_tvalid && m_tready) begin
            got.status        = m_tuser[0];
            got.node_out      = m_tdata[3:0];
            got.cost_out      = m_tdata[19:4];
            got.is_active     = m_tdata[20];
            got.is_heard      = m_tdata[21];
            got.is_discovered = m_tdata[22];
            got.id_valid      = m_tuser[1];
            got.last          = m_tlast;
            if (expected_words.size() == 0) begin
                word_errors++;
                if (word_errors <= 10)
                    $display("%0t: unexpected word: %s", $time, word_text(got));
            end else begin
                want = expected_words.pop_front();
                if (got.status !== want.status || got.node_out !== want.node_out ||
                    got.cost_out !== want.cost_out || got.is_active !== want.is_active ||
                    got.is_heard !== want.is_heard ||
                    got.is_discovered !== want.is_discovered ||
                    got.id_valid !== want.id_valid || got.last !== want.last) begin
                    word_errors++;
                    if (word_errors <= 10) begin
                        $display("%0t: word mismatch", $time);
                        $display("    expected %s", word_text(want));
                        $display("    actual   %s", word_text(got));
                    end
                end
            end
        end
    end

    initial begin
        i_rst_n    <= 1'b0;
        s_tvalid   <= 1'b0;
        s_tdata    <= '0;
        s_tuser    <= '0;
        i_cfg_we   <= 1'b0;
        i_cfg_idx  <= CFG_OWN_NODE;
        i_cfg_data <= '0;
        table_reset();
        repeat (6) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        test_empty_table();
        test_entry_commands();
        test_lists();
        test_ttl_limits();
        test_random_traffic();

        drain();
        if (word_errors == 0 && expected_words.size() == 0) begin
            $display("*** PASSED ***");
        end else begin
            $display("*** FAILED ***");
        end
        $finish;
    end

    // Hard stop well beyond the slowest correct run
    initial begin
        #3_000_000;
        $display("*** FAILED ***");
        $finish;
    end

endmodule

@@ filelist.f @@
hdl/nhm_pkg.sv
hdl/nhm_entry_eval.sv
hdl/neighbor_heartbeat_monitor.sv
test/neighbor_heartbeat_monitor_tb.sv
